// File: sv/cmap_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmap_pkg: shared constants for the gradient colormap lookup
// Register indexes, register widths and register reset values.
// ----------------------------------------------------------------------------
package cmap_pkg;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 32;
  localparam int StopRegs = 4;
  localparam int StopIdxW = 2;
  localparam int ChanW    = 8;
  localparam int NumChans = 4;

  localparam logic [CfgIdxW-1:0] RegMinValue  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegRangeRecp = 3'd1;
  localparam logic [CfgIdxW-1:0] RegStop0     = 3'd2;
  localparam logic [CfgIdxW-1:0] RegStop1     = 3'd3;
  localparam logic [CfgIdxW-1:0] RegStop2     = 3'd4;
  localparam logic [CfgIdxW-1:0] RegStop3     = 3'd5;

  localparam logic [CfgDataW-1:0] MinValueRst  = 32'h0000_0000;
  localparam logic [CfgDataW-1:0] RangeRecpRst = 32'h0001_0000;
  localparam logic [CfgDataW-1:0] Stop0Rst     = 32'hFF00_00FF;
  localparam logic [CfgDataW-1:0] Stop1Rst     = 32'hFFFF_00FF;
  localparam logic [CfgDataW-1:0] Stop2Rst     = 32'h00FF_00FF;
  localparam logic [CfgDataW-1:0] Stop3Rst     = 32'h0000_FFFF;

  localparam logic [ChanW-1:0] ChanMax = 8'hFF;

endpackage

// File: sv/cmap_lerp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmap_lerp: one color channel blend
// Registers both weighted terms, then rounds half up and saturates.
// ----------------------------------------------------------------------------
module cmap_lerp #(
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [cmap_pkg::ChanW-1:0]  start_i,
  input  logic [cmap_pkg::ChanW-1:0]  end_i,
  input  logic [FRAC_BITS:0]          frac_i,
  output logic [cmap_pkg::ChanW-1:0]  level_o
);

  localparam int FW = FRAC_BITS + 1;
  localparam int PW = FRAC_BITS + cmap_pkg::ChanW + 1;
  localparam int SW = PW + 1;
  localparam logic [FW-1:0] One  = FW'(1) << FRAC_BITS;
  localparam logic [SW-1:0] Half = SW'(1) << (FRAC_BITS - 1);

  logic [PW-1:0] term_a_d, term_a_q;
  logic [PW-1:0] term_b_d, term_b_q;
  logic [SW-1:0] sum;
  logic [SW-FRAC_BITS-1:0] rounded;

  assign term_a_d = PW'(start_i) * PW'(One - frac_i);
  assign term_b_d = PW'(end_i) * PW'(frac_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      term_a_q <= term_a_d;
      term_b_q <= term_b_d;
    end
  end

  assign sum     = SW'(term_a_q) + SW'(term_b_q) + Half;
  assign rounded = sum[SW-1:FRAC_BITS];
  assign level_o = (rounded > (SW-FRAC_BITS)'(cmap_pkg::ChanMax)) ? cmap_pkg::ChanMax
                                                                   : rounded[7:0];

endmodule

// File: sv/gradient_colormap_lookup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gradient_colormap_lookup: piecewise linear sample-to-RGBA colormap
// Normalizes a signed Q16.16 sample against a programmable minimum and
// range reciprocal, picks a segment between color stops and blends.
// ----------------------------------------------------------------------------
//
//  channel | handshake                 | payload
//  --------+---------------------------+--------------------------------------
//  input   | in_valid_i / in_ready_o   | sample_value_i, sample_is_nan_i
//  output  | out_valid_o / out_ready_i | red/green/blue/alpha_level_o
//  config  | cfg_we_i (no wait)        | cfg_idx_i, cfg_wdata_i
//
//  One item per clock sustained while results are taken; acceptance leads to
//  out_valid_o through the stages subtract, multiply, segment pick, blend
//  products and round into the output register.
//  All stages advance together whenever the output register is empty or is
//  being taken; otherwise the whole pipe holds, bubbles included.
//  Reset clears valid bits and loads the register reset values.
//
module gradient_colormap_lookup #(
  parameter int NUM_STOPS = 4,
  parameter int FRAC_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration
  input  logic                           cfg_we_i,
  input  logic [cmap_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [cmap_pkg::CfgDataW-1:0]  cfg_wdata_i,
  // input items
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [31:0]             sample_value_i,
  input  logic                           sample_is_nan_i,
  // result items
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [7:0]                     red_level_o,
  output logic [7:0]                     green_level_o,
  output logic [7:0]                     blue_level_o,
  output logic [7:0]                     alpha_level_o
);

  localparam int FW = FRAC_BITS + 1;   // fraction incl. the value one
  localparam int SW = FRAC_BITS + 2;   // scaled position, below 3*ONE
  localparam logic [FW-1:0] One = FW'(1) << FRAC_BITS;
  localparam logic [cmap_pkg::StopIdxW-1:0] LastSeg = cmap_pkg::StopIdxW'(NUM_STOPS - 2);

  // Per-item flags that ride along with the data.
  typedef struct packed {
    logic valid;
    logic nan;
  } stage_flags_t;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic signed [31:0]              min_value_q;
  logic [31:0]                     range_recp_q;
  logic [cmap_pkg::CfgDataW-1:0]   stop_q [cmap_pkg::StopRegs];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_value_q  <= cmap_pkg::MinValueRst;
      range_recp_q <= cmap_pkg::RangeRecpRst;
      stop_q[0]    <= cmap_pkg::Stop0Rst;
      stop_q[1]    <= cmap_pkg::Stop1Rst;
      stop_q[2]    <= cmap_pkg::Stop2Rst;
      stop_q[3]    <= cmap_pkg::Stop3Rst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        cmap_pkg::RegMinValue:  min_value_q  <= cfg_wdata_i;
        cmap_pkg::RegRangeRecp: range_recp_q <= cfg_wdata_i;
        cmap_pkg::RegStop0:     stop_q[0]    <= cfg_wdata_i;
        cmap_pkg::RegStop1:     stop_q[1]    <= cfg_wdata_i;
        cmap_pkg::RegStop2:     stop_q[2]    <= cfg_wdata_i;
        cmap_pkg::RegStop3:     stop_q[3]    <= cfg_wdata_i;
        default: ;  // unknown index: drop the write
      endcase
    end
  end

  // Global advance: the pipe moves when the output register can take an item.
  logic adv;
  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  // --------------------------------------------------------------------------
  // Stage 1: exact 33-bit difference, empty-range check
  // --------------------------------------------------------------------------
  stage_flags_t       s1_q;
  logic signed [32:0] diff_d, diff_q;
  logic               empty1_q;

  assign diff_d = 33'(sample_value_i) - 33'(min_value_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
    end else if (adv) begin
      s1_q <= '{valid: in_valid_i, nan: sample_is_nan_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      diff_q   <= diff_d;
      empty1_q <= (range_recp_q == '0);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: 32x32 product of positive difference and reciprocal (Q32.32)
  // --------------------------------------------------------------------------
  stage_flags_t s2_q;
  logic [63:0]  prod_q;
  logic         pos2_q;
  logic         empty2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_q <= '0;
    end else if (adv) begin
      s2_q <= s1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      prod_q   <= 64'(diff_q[31:0]) * 64'(range_recp_q);
      pos2_q   <= !diff_q[32] && (diff_q != '0);
      empty2_q <= empty1_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: truncate to FRAC_BITS, saturate at one, pick segment and fraction.
  // The normalized value reaches one exactly when the integer half of the
  // product is nonzero; that case and the empty range both force the end of
  // the last segment, which blends to the last stop exactly.
  // --------------------------------------------------------------------------
  stage_flags_t                    s3_q;
  logic [FRAC_BITS-1:0]            norm;
  logic [SW-1:0]                   scaled;
  logic [cmap_pkg::StopIdxW-1:0]   seg_raw, seg_d, seg_q;
  logic [SW-1:0]                   frac_full;
  logic [FW-1:0]                   frac_d, frac_q;
  logic                            at_end;

  assign at_end    = empty2_q || (pos2_q && (prod_q[63:32] != '0));
  assign norm      = pos2_q ? prod_q[31:32-FRAC_BITS] : '0;
  assign scaled    = SW'(norm) * SW'(NUM_STOPS - 1);
  assign seg_raw   = scaled[SW-1:FRAC_BITS];

  always_comb begin
    if (at_end) begin
      seg_d = LastSeg;
    end else if (seg_raw > LastSeg) begin
      seg_d = LastSeg;
    end else begin
      seg_d = seg_raw;
    end
  end

  assign frac_full = scaled - (SW'(seg_d) << FRAC_BITS);
  assign frac_d    = at_end ? One : frac_full[FW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_q <= '0;
    end else if (adv) begin
      s3_q <= s2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      seg_q  <= seg_d;
      frac_q <= frac_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stages 4 and 5: per-channel blend between the two stops of the segment
  // --------------------------------------------------------------------------
  stage_flags_t                  s4_q;
  logic [cmap_pkg::StopIdxW-1:0] seg_next;
  logic [cmap_pkg::CfgDataW-1:0] stop_a, stop_b;
  logic [cmap_pkg::ChanW-1:0]    level [cmap_pkg::NumChans];

  assign seg_next = seg_q + cmap_pkg::StopIdxW'(1);
  assign stop_a   = stop_q[seg_q];
  assign stop_b   = stop_q[seg_next];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_q <= '0;
    end else if (adv) begin
      s4_q <= s3_q;
    end
  end

  // Channel 0 is red, taken from the top byte of a stop.
  for (genvar ch = 0; ch < cmap_pkg::NumChans; ch++) begin : g_chan
    cmap_lerp #(
      .FRAC_BITS (FRAC_BITS)
    ) u_lerp (
      .clk_i   (clk_i),
      .en_i    (adv),
      .start_i (stop_a[cmap_pkg::ChanW*(cmap_pkg::NumChans-1-ch) +: cmap_pkg::ChanW]),
      .end_i   (stop_b[cmap_pkg::ChanW*(cmap_pkg::NumChans-1-ch) +: cmap_pkg::ChanW]),
      .frac_i  (frac_q),
      .level_o (level[ch])
    );
  end

  // Output register; a missing sample overrides everything with opaque white.
  logic       out_valid_q;
  logic [7:0] red_q, green_q, blue_q, alpha_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= s4_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      red_q   <= s4_q.nan ? cmap_pkg::ChanMax : level[0];
      green_q <= s4_q.nan ? cmap_pkg::ChanMax : level[1];
      blue_q  <= s4_q.nan ? cmap_pkg::ChanMax : level[2];
      alpha_q <= s4_q.nan ? cmap_pkg::ChanMax : level[3];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign red_level_o   = red_q;
  assign green_level_o = green_q;
  assign blue_level_o  = blue_q;
  assign alpha_level_o = alpha_q;

endmodule

// File: sv/cmap_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmap_checker: port-level checks for the gradient colormap lookup
// Watches handshakes, reset and the missing-sample path from the ports.
// ----------------------------------------------------------------------------
module cmap_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       sample_is_nan_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] red_level_o,
  input logic [7:0] green_level_o,
  input logic [7:0] blue_level_o,
  input logic [7:0] alpha_level_o
);

  // A stalled result holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(red_level_o) &&
      $stable(green_level_o) && $stable(blue_level_o) && $stable(alpha_level_o))
    else $error("stalled result changed");

  // Input side accepts whenever the output register is free or draining.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("in_ready_o does not follow output state");

  // No result shows right after reset is released.
  assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result valid out of reset");

  // Missing sample with the sink always ready comes out as white.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && sample_is_nan_i ##1 out_ready_i ##1 out_ready_i
      ##1 out_ready_i ##1 out_ready_i |=> out_valid_o && (red_level_o == 8'hFF) &&
      (green_level_o == 8'hFF) && (blue_level_o == 8'hFF) && (alpha_level_o == 8'hFF))
    else $error("missing sample not mapped to white");

endmodule

bind gradient_colormap_lookup cmap_checker u_cmap_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .sample_is_nan_i (sample_is_nan_i),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .red_level_o     (red_level_o),
  .green_level_o   (green_level_o),
  .blue_level_o    (blue_level_o),
  .alpha_level_o   (alpha_level_o)
);

// File: test/colormap_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// colormap_checker: result checker for the gradient colormap lookup
// Snoops register writes and both item channels, predicts the RGBA color of
// every accepted sample and compares it, channel by channel, with the
// oldest color still owed by the block.
// ----------------------------------------------------------------------------
module colormap_checker
  import cmap_pkg::*;
#(
  parameter int NUM_STOPS = 4,
  parameter int FRAC_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic signed [31:0]  sample_value_i,
  input  logic                sample_is_nan_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic [ChanW-1:0]    red_level_i,
  input  logic [ChanW-1:0]    green_level_i,
  input  logic [ChanW-1:0]    blue_level_i,
  input  logic [ChanW-1:0]    alpha_level_i,
  output int                  mismatch_count_o,
  output int                  pending_o,
  output int                  samples_seen_o,
  output int                  missing_hits_o,
  output int                  empty_range_hits_o,
  output int                  below_min_hits_o
);

  localparam logic [63:0] One        = 64'd1 << FRAC_BITS;
  localparam int          MaxReports = 10;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic [ChanW-1:0] alpha;
  } rgba_t;

  // shadow copy of the register file
  logic signed [31:0] floor_q;
  logic [31:0]        recip_q;
  rgba_t              stop_q [StopRegs];

  rgba_t owed_colors [$];
  rgba_t want, got;

  function automatic logic [ChanW-1:0] blend_level(input logic [ChanW-1:0] from_level,
                                                   input logic [ChanW-1:0] to_level,
                                                   input logic [63:0]      frac);
    logic [63:0] acc;
    acc = (64'(from_level) * (One - frac) + 64'(to_level) * frac + (One >> 1)) >> FRAC_BITS;
    return (acc > 64'(ChanMax)) ? ChanMax : acc[ChanW-1:0];
  endfunction

  function automatic rgba_t map_sample_to_color(input logic signed [31:0] value,
                                                input logic               missing);
    logic signed [32:0] delta;
    logic [63:0]        product;
    logic [63:0]        level;
    logic [63:0]        scaled;
    logic [63:0]        frac;
    int                 seg;
    rgba_t              lo_c, hi_c, mixed;
    if (missing) return {ChanMax, ChanMax, ChanMax, ChanMax};
    if (recip_q == '0) return stop_q[NUM_STOPS-1];
    delta = value - floor_q;
    if (delta <= 0) begin
      level = '0;
    end else begin
      product = 64'($unsigned(delta)) * 64'(recip_q);
      level = product >> (32 - FRAC_BITS);
      if (level > One) level = One;
    end
    // a normalized value of one pins to the last stop
    if (level >= One) return stop_q[NUM_STOPS-1];
    scaled = level * (NUM_STOPS - 1);
    seg = int'(scaled >> FRAC_BITS);
    if (seg > NUM_STOPS - 2) seg = NUM_STOPS - 2;
    frac = scaled - (64'(seg) << FRAC_BITS);
    lo_c = stop_q[seg];
    hi_c = stop_q[seg+1];
    mixed.red   = blend_level(lo_c.red,   hi_c.red,   frac);
    mixed.green = blend_level(lo_c.green, hi_c.green, frac);
    mixed.blue  = blend_level(lo_c.blue,  hi_c.blue,  frac);
    mixed.alpha = blend_level(lo_c.alpha, hi_c.alpha, frac);
    return mixed;
  endfunction

  task automatic flag_color(input bit owed, input rgba_t wanted, input rgba_t seen);
    mismatch_count_o++;
    if (mismatch_count_o <= MaxReports) begin
      if (owed)
        $display("%0t: color mismatch, expected %02h %02h %02h %02h, got %02h %02h %02h %02h",
                 $time, wanted.red, wanted.green, wanted.blue, wanted.alpha,
                 seen.red, seen.green, seen.blue, seen.alpha);
      else
        $display("%0t: color with no sample waiting, got %02h %02h %02h %02h",
                 $time, seen.red, seen.green, seen.blue, seen.alpha);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      floor_q   = MinValueRst;
      recip_q   = RangeRecpRst;
      stop_q[0] = Stop0Rst;
      stop_q[1] = Stop1Rst;
      stop_q[2] = Stop2Rst;
      stop_q[3] = Stop3Rst;
      owed_colors.delete();
      mismatch_count_o   = 0;
      samples_seen_o     = 0;
      missing_hits_o     = 0;
      empty_range_hits_o = 0;
      below_min_hits_o   = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegMinValue:  floor_q = cfg_wdata_i;
          RegRangeRecp: recip_q = cfg_wdata_i;
          RegStop0, RegStop1, RegStop2, RegStop3: begin
            stop_q[cfg_idx_i - RegStop0] = cfg_wdata_i;
          end
          default: ;  // past the register list: dropped
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        owed_colors.push_back(map_sample_to_color(sample_value_i, sample_is_nan_i));
        samples_seen_o++;
        if (sample_is_nan_i) missing_hits_o++;
        else if (recip_q == '0) empty_range_hits_o++;
        else if (sample_value_i <= floor_q) below_min_hits_o++;
      end
      if (out_valid_i && out_ready_i) begin
        got = {red_level_i, green_level_i, blue_level_i, alpha_level_i};
        if (owed_colors.size() == 0) begin
          flag_color(1'b0, got, got);
        end else begin
          want = owed_colors.pop_front();
          if (got.red !== want.red || got.green !== want.green ||
              got.blue !== want.blue || got.alpha !== want.alpha)
            flag_color(1'b1, want, got);
        end
      end
    end
    pending_o = owed_colors.size();
  end

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the gradient colormap lookup
// Programs a series of register settings (reset values, both extremes, an
// empty range, random ranges) and streams samples through the block with
// random idling on both channels; colormap_checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
  import cmap_pkg::*;

  localparam int NumStops       = 4;
  localparam int FracBits       = 16;
  localparam int NumPhases      = 8;
  localparam int ItemsPerPhase  = 54;
  localparam int HoldPhase      = 4;   // receiver parks for a long stretch here
  localparam int PausePhase     = 5;   // sender drains mid-stream here
  localparam int LongHoldCycles = 60;
  localparam int TailCycles     = 20;  // pipe is five deep; give it room
  localparam int StallLimit     = 2000;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;
  logic                in_valid;
  logic                in_ready;
  logic signed [31:0]  sample_value;
  logic                sample_is_nan;
  logic                out_valid;
  logic                out_ready;
  logic [ChanW-1:0]    red_level, green_level, blue_level, alpha_level;

  int mismatches, pending, samples_seen, missing_hits, empty_range_hits, below_min_hits;

  // set by the sender, read by the result sink and the sender's pause logic
  bit hold_results;
  bit idle_off;

  // window of sample values that the current setting maps onto the stops
  longint span_lo;
  longint span;

  gradient_colormap_lookup #(
    .NUM_STOPS(NumStops),
    .FRAC_BITS(FracBits)
  ) dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .sample_value_i (sample_value),
    .sample_is_nan_i(sample_is_nan),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .red_level_o    (red_level),
    .green_level_o  (green_level),
    .blue_level_o   (blue_level),
    .alpha_level_o  (alpha_level)
  );

  colormap_checker #(
    .NUM_STOPS(NumStops),
    .FRAC_BITS(FracBits)
  ) checker_inst (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_we_i          (cfg_we),
    .cfg_idx_i         (cfg_idx),
    .cfg_wdata_i       (cfg_wdata),
    .in_valid_i        (in_valid),
    .in_ready_i        (in_ready),
    .sample_value_i    (sample_value),
    .sample_is_nan_i   (sample_is_nan),
    .out_valid_i       (out_valid),
    .out_ready_i       (out_ready),
    .red_level_i       (red_level),
    .green_level_i     (green_level),
    .blue_level_i      (blue_level),
    .alpha_level_i     (alpha_level),
    .mismatch_count_o  (mismatches),
    .pending_o         (pending),
    .samples_seen_o    (samples_seen),
    .missing_hits_o    (missing_hits),
    .empty_range_hits_o(empty_range_hits),
    .below_min_hits_o  (below_min_hits)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Drop valid for a random burst now and then; back-to-back runs otherwise.
  task automatic pause_sender();
    if (!idle_off && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  endtask

  // Present one item and hold it until the block takes it. Called and
  // returns at a falling edge; valid stays high when the next item follows.
  task automatic offer_sample(input logic signed [31:0] value, input logic missing);
    sample_value  = value;
    sample_is_nan = missing;
    in_valid      = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    pause_sender();
  endtask

  // Mostly samples inside the mapped window, some right on the segment
  // boundaries, the rest missing values and full-range noise.
  task automatic offer_random_sample();
    longint             pick;
    logic signed [31:0] value;
    logic               missing;
    int                 kind;
    kind    = $urandom_range(0, 99);
    missing = 1'b0;
    if (kind < 70) begin
      pick = span_lo + longint'({$urandom, $urandom} % (span + 1));
    end else if (kind < 80) begin
      pick = span_lo + (span * longint'($urandom_range(0, 3))) / 3
             + longint'($urandom_range(0, 2)) - 1;
    end else begin
      pick    = longint'(int'($urandom));
      missing = (kind < 88);
    end
    if (pick > 64'sd2147483647) pick = 64'sd2147483647;
    if (pick < -64'sd2147483648) pick = -64'sd2147483648;
    value = pick[31:0];
    offer_sample(value, missing);
  endtask

  // Stop offering and wait for every owed color to come back.
  task automatic drain_results();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = data;
    @(negedge clk);
  endtask

  function automatic logic [CfgDataW-1:0] random_stop();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Phase 0 and 1 take the extremes, phase 2 an empty range plus writes past
  // the register list, the rest random windows of widely varying width.
  task automatic program_setting(input int phase);
    logic [CfgDataW-1:0] floor_word;
    logic [CfgDataW-1:0] recip_word;
    logic [CfgDataW-1:0] stops [StopRegs];
    int                  span_log;
    span_log = $urandom_range(1, 31);
    span     = (64'sd1 << span_log) + longint'($urandom) % (64'sd1 << span_log);
    span_lo  = -64'sd2147483648 + longint'($urandom) % ((64'sd1 << 32) - span + 1);
    recip_word = 32'((64'sd1 << 32) / span);
    floor_word = span_lo[31:0];
    foreach (stops[i]) stops[i] = random_stop();
    case (phase)
      0: begin
        floor_word = 32'h8000_0000;
        span_lo    = -64'sd2147483648;
        recip_word = '1;
        span       = 1;
        stops      = '{'0, '1, '0, '1};
      end
      1: begin
        floor_word = 32'h7FFF_FFFF;
        span_lo    = 64'sd2147483647;
        recip_word = 32'd1;
        span       = 64'sd1 << 32;
        stops      = '{'1, '0, '1, '0};
      end
      2: recip_word = '0;
      default: ;
    endcase
    write_reg(RegMinValue, floor_word);
    write_reg(RegRangeRecp, recip_word);
    write_reg(RegStop0, stops[0]);
    write_reg(RegStop1, stops[1]);
    write_reg(RegStop2, stops[2]);
    write_reg(RegStop3, stops[3]);
    if (phase == 2) begin
      for (int idx = RegStop3 + 1; idx < (1 << CfgIdxW); idx++)
        write_reg(CfgIdxW'(idx), $urandom);
    end
    cfg_we = 1'b0;
  endtask

  // Result sink: random stall bursts, one long hold-off on request, and
  // always ready once idling is switched off.
  initial begin : result_sink
    bit held_off;
    held_off  = 1'b0;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_results && !held_off) begin
        out_ready = 1'b0;
        repeat (LongHoldCycles - 1) @(negedge clk);
        held_off = 1'b1;
      end else if (!idle_off && $urandom_range(0, 5) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(0, 11)) @(negedge clk);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // Abort when no item moves on either channel for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
      if (quiet >= StallLimit) begin
        $display("watchdog: no item moved for %0d cycles", StallLimit);
        $display("** gradient_colormap_lookup: FAILED **");
        $finish;
      end
    end
  end

  initial begin : stimulus
    hold_results  = 1'b0;
    idle_off      = 1'b0;
    span_lo       = 0;
    span          = 64'sd1 << FracBits;
    in_valid      = 1'b0;
    sample_value  = '0;
    sample_is_nan = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = RegMinValue;
    cfg_wdata     = '0;
    rst_n         = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset setting: minimum 0, range 1.0, so the sample is the normalized
    // value itself and the segment edges sit at 1/3 and 2/3.
    offer_sample(32'sh0000_0000, 1'b1);   // missing value wins over everything
    offer_sample(32'sh7FFF_FFFF, 1'b1);
    offer_sample(32'sh8000_0000, 1'b0);   // most negative: first stop
    offer_sample(32'sh7FFF_FFFF, 1'b0);   // most positive: saturates to last stop
    offer_sample(32'sh0000_0000, 1'b0);   // exactly the minimum
    offer_sample(32'shFFFF_FFFF, 1'b0);   // one step below the minimum
    offer_sample(32'sd1, 1'b0);
    offer_sample(32'sd10922, 1'b0);
    offer_sample(32'sd21845, 1'b0);       // last step of the first segment
    offer_sample(32'sd21846, 1'b0);       // first step of the second
    offer_sample(32'sd32768, 1'b0);
    offer_sample(32'sd43690, 1'b0);
    offer_sample(32'sd43691, 1'b0);
    offer_sample(32'sd54613, 1'b0);
    offer_sample(32'sd65535, 1'b0);       // just short of one
    offer_sample(32'sd65536, 1'b0);       // exactly one: last stop
    offer_sample(32'sd65537, 1'b0);

    for (int phase = 0; phase < NumPhases; phase++) begin
      drain_results();
      program_setting(phase);
      idle_off = (phase == NumPhases - 1);
      if (phase == HoldPhase) hold_results = 1'b1;
      for (int n = 0; n < ItemsPerPhase; n++) begin
        if (phase == PausePhase && n == ItemsPerPhase / 2) drain_results();
        offer_random_sample();
      end
    end

    drain_results();
    repeat (TailCycles) @(negedge clk);

    $display("Mapped %0d samples under %0d register settings: %0d missing,",
             samples_seen, NumPhases + 1, missing_hits);
    $display("%0d empty range, %0d at or below the minimum; a %0d-cycle output %s",
             empty_range_hits, below_min_hits, LongHoldCycles,
             "hold-off, a mid-stream drain and a closing run at full rate.");
    if (mismatches == 0 && pending == 0)
      $display("** gradient_colormap_lookup: PASSED **");
    else
      $display("** gradient_colormap_lookup: FAILED **");
    $finish;
  end

endmodule
